// ===== rtl/fpr_pkg.sv =====
// Shared types and constants of the firewall protection register bank.
package fpr_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned ADDR_W         = 8;
  localparam int unsigned IDX_W          = 3;
  localparam int unsigned LOCK_IDX_W     = 2;
  localparam int unsigned ZONE_IDX_W     = 2;
  localparam int unsigned PROT_WORDS_MAX = 8;
  localparam int unsigned LOCK_WORDS_MAX = 4;
  localparam int unsigned ZONES_MAX      = 4;
  localparam int unsigned PER_PROT_WORD  = 16;
  localparam int unsigned PER_LOCK_WORD  = 32;
  localparam int unsigned ZONE_SIZE_W    = 10;
  localparam int unsigned ZONE_LOCK_POS  = 31;
  localparam int unsigned ATTR_W         = 2;
  localparam int unsigned CNT_W          = 8;

  localparam logic [ADDR_W-1:0] ZONE_BASE_W = 8'd0;
  localparam logic [ADDR_W-1:0] PROT_BASE_W = 8'd4;
  localparam logic [ADDR_W-1:0] LOCK_BASE_W = 8'd12;
  localparam logic [ADDR_W-1:0] HWCFG_W     = 8'd252;
  localparam logic [ADDR_W-1:0] VERSION_W   = 8'd253;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ZONE,
    KIND_PROT,
    KIND_LOCK,
    KIND_HWCFG,
    KIND_VERSION,
    KIND_BAD
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] idx;
  } dec_t;

endpackage

// ===== rtl/firewall_protection_register_bank_top.sv =====
// Top level of the firewall protection register bank.
// An accepted beat is held in the request registers, then in the result registers that raise done_o.
// Throughput: one access per cycle; busy stays low, the result register
// always takes the beat, as the receiver cannot stall.
// Reset (rst_ni, asynchronous, active low) clears all zones, attributes and
// locks and empties the pipeline.
module firewall_protection_register_bank_top import fpr_pkg::*; #(
  parameter int unsigned NUM_PERIPH = 128,
  parameter int unsigned NUM_ZONES  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cmd_i,
  input  logic [ADDR_W-1:0] word_addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              done_o,
  output logic [DATA_W-1:0] rdata_o,
  output logic              bad_address_o
);

  logic              vld_q, vld_d;
  logic              cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;
  logic              done_q;
  logic [DATA_W-1:0] rdata_q, rdata_d;
  logic              bad_q, bad_d;
  dec_t              dec;
  logic              wr;

  assign busy  = 1'b0;
  assign vld_d = start && !busy;
  assign wr    = (cmd_q == CMD_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_d) begin
      cmd_q   <= cmd_i;
      addr_q  <= word_addr_i;
      wdata_q <= wdata_i;
    end
    if (vld_q) begin
      rdata_q <= rdata_d;
      bad_q   <= bad_d;
    end
  end

  fpr_decode #(
    .NUM_PERIPH (NUM_PERIPH),
    .NUM_ZONES  (NUM_ZONES)
  ) u_decode (
    .addr_i (addr_q),
    .dec_o  (dec)
  );

  fpr_regs #(
    .NUM_PERIPH (NUM_PERIPH),
    .NUM_ZONES  (NUM_ZONES)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q),
    .wr_i    (wr),
    .dec_i   (dec),
    .wdata_i (wdata_q),
    .rdata_o (rdata_d)
  );

  assign bad_d         = (dec.kind == KIND_BAD);
  assign done_o        = done_q;
  assign rdata_o       = rdata_q;
  assign bad_address_o = bad_q;

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ##1 done_o)
    else $error("accepted beat produced no result strobe");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && cmd_q == CMD_WRITE |=> rdata_o == '0)
    else $error("write beat returned non-zero read data");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && bad_address_o |-> rdata_o == '0)
    else $error("unmapped address returned non-zero read data");
`endif

endmodule

// ===== rtl/fpr_decode.sv =====
// Word address decoder: register group and word index within the group.
module fpr_decode import fpr_pkg::*; #(
  parameter int unsigned NUM_PERIPH = 128,
  parameter int unsigned NUM_ZONES  = 2
) (
  input  logic [ADDR_W-1:0] addr_i,
  output dec_t              dec_o
);

  localparam int unsigned PROT_WORDS = (NUM_PERIPH + PER_PROT_WORD - 1) / PER_PROT_WORD;
  localparam int unsigned LOCK_WORDS = (NUM_PERIPH + PER_LOCK_WORD - 1) / PER_LOCK_WORD;
  localparam logic [ADDR_W-1:0] ZONE_END = ZONE_BASE_W + ADDR_W'(NUM_ZONES);
  localparam logic [ADDR_W-1:0] PROT_END = PROT_BASE_W + ADDR_W'(PROT_WORDS);
  localparam logic [ADDR_W-1:0] LOCK_END = LOCK_BASE_W + ADDR_W'(LOCK_WORDS);

  logic [ADDR_W-1:0] off;

  always_comb begin
    dec_o.kind = KIND_BAD;
    off        = '0;
    if (addr_i < ZONE_END) begin
      dec_o.kind = KIND_ZONE;
      off        = addr_i - ZONE_BASE_W;
    end else if (addr_i >= PROT_BASE_W && addr_i < PROT_END) begin
      dec_o.kind = KIND_PROT;
      off        = addr_i - PROT_BASE_W;
    end else if (addr_i >= LOCK_BASE_W && addr_i < LOCK_END) begin
      dec_o.kind = KIND_LOCK;
      off        = addr_i - LOCK_BASE_W;
    end else if (addr_i == HWCFG_W) begin
      dec_o.kind = KIND_HWCFG;
    end else if (addr_i == VERSION_W) begin
      dec_o.kind = KIND_VERSION;
    end
    dec_o.idx = off[IDX_W-1:0];
  end

endmodule

// ===== rtl/fpr_regs.sv =====
// Zone, protection and lock storage with write update and read mux.
module fpr_regs import fpr_pkg::*; #(
  parameter int unsigned NUM_PERIPH = 128,
  parameter int unsigned NUM_ZONES  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              wr_i,
  input  dec_t              dec_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [ATTR_W-1:0]      attr_q [NUM_PERIPH];
  logic [NUM_PERIPH-1:0]  locked_q;
  logic [ZONE_SIZE_W-1:0] zsize_q [NUM_ZONES];
  logic [NUM_ZONES-1:0]   zlock_q;

  logic [PROT_WORDS_MAX-1:0][PER_PROT_WORD-1:0][ATTR_W-1:0] attr_pad;
  logic [LOCK_WORDS_MAX-1:0][PER_LOCK_WORD-1:0]             lock_pad;
  logic [ZONES_MAX-1:0][ZONE_SIZE_W-1:0]                    zsize_pad;
  logic [ZONES_MAX-1:0]                                     zlock_pad;
  logic [DATA_W-1:0]                                        rd;
  logic                                                     wr_en;

  assign wr_en = valid_i && wr_i;

  for (genvar i = 0; i < NUM_PERIPH; i++) begin : g_per
    localparam int unsigned PW = i / PER_PROT_WORD;
    localparam int unsigned PK = i % PER_PROT_WORD;
    localparam int unsigned LW = i / PER_LOCK_WORD;
    localparam int unsigned LK = i % PER_LOCK_WORD;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        attr_q[i]   <= '0;
        locked_q[i] <= 1'b0;
      end else if (wr_en) begin
        if (dec_i.kind == KIND_PROT && dec_i.idx == IDX_W'(PW) && !locked_q[i]) begin
          attr_q[i] <= wdata_i[ATTR_W*PK +: ATTR_W];
        end
        if (dec_i.kind == KIND_LOCK && dec_i.idx == IDX_W'(LW) && wdata_i[LK]) begin
          locked_q[i] <= 1'b1;
        end
      end
    end

    assign attr_pad[PW][PK] = attr_q[i];
    assign lock_pad[LW][LK] = locked_q[i];
  end

  for (genvar i = NUM_PERIPH; i < PROT_WORDS_MAX * PER_PROT_WORD; i++) begin : g_attr_pad
    assign attr_pad[i / PER_PROT_WORD][i % PER_PROT_WORD] = '0;
  end

  for (genvar i = NUM_PERIPH; i < LOCK_WORDS_MAX * PER_LOCK_WORD; i++) begin : g_lock_pad
    assign lock_pad[i / PER_LOCK_WORD][i % PER_LOCK_WORD] = 1'b0;
  end

  for (genvar z = 0; z < NUM_ZONES; z++) begin : g_zone
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        zsize_q[z] <= '0;
        zlock_q[z] <= 1'b0;
      end else if (wr_en && dec_i.kind == KIND_ZONE && dec_i.idx == IDX_W'(z) && !zlock_q[z]) begin
        zsize_q[z] <= wdata_i[ZONE_SIZE_W-1:0];
        if (wdata_i[ZONE_LOCK_POS]) begin
          zlock_q[z] <= 1'b1;
        end
      end
    end

    assign zsize_pad[z] = zsize_q[z];
    assign zlock_pad[z] = zlock_q[z];
  end

  for (genvar z = NUM_ZONES; z < ZONES_MAX; z++) begin : g_zone_pad
    assign zsize_pad[z] = '0;
    assign zlock_pad[z] = 1'b0;
  end

  always_comb begin
    rd = '0;
    unique case (dec_i.kind)
      KIND_ZONE: begin
        rd[ZONE_SIZE_W-1:0] = zsize_pad[dec_i.idx[ZONE_IDX_W-1:0]];
        rd[ZONE_LOCK_POS]   = zlock_pad[dec_i.idx[ZONE_IDX_W-1:0]];
      end
      KIND_PROT: rd = attr_pad[dec_i.idx];
      KIND_LOCK: rd = lock_pad[dec_i.idx[LOCK_IDX_W-1:0]];
      KIND_HWCFG: begin
        rd[CNT_W-1:0]       = CNT_W'(NUM_ZONES);
        rd[2*CNT_W-1:CNT_W] = CNT_W'(NUM_PERIPH);
      end
      default: rd = '0;
    endcase
  end

  assign rdata_o = wr_i ? '0 : rd;

endmodule
